[rtl/tdeg_pkg.sv]
// shared types, register-file map and op sequence for the triangle deformation energy block
// depends on nothing; used by tdeg_front, tdeg_back and the top level
`timescale 1ns / 1ps

package tdeg_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_WORDS     = 10;
  localparam int unsigned IN_W          = 320;
  localparam int unsigned OUT_W         = 416;
  localparam int unsigned ACC_W         = 68;
  localparam int unsigned PROD_W        = 66;
  localparam int unsigned STEP_W        = 7;
  localparam longint      S32_MAX       = 64'sd2147483647;
  localparam longint      S32_MIN       = -64'sd2147483648;

  typedef struct packed {
    logic [NUM_WORDS-1:0][31:0] word;
    logic                       last;
  } item_t;

  // register file map
  localparam logic [4:0] R_F0X = 5'd0;
  localparam logic [4:0] R_F0Y = 5'd1;
  localparam logic [4:0] R_F0Z = 5'd2;
  localparam logic [4:0] R_F1X = 5'd3;
  localparam logic [4:0] R_F1Y = 5'd4;
  localparam logic [4:0] R_F1Z = 5'd5;
  localparam logic [4:0] R_MA  = 5'd6;
  localparam logic [4:0] R_MB  = 5'd7;
  localparam logic [4:0] R_MD  = 5'd8;
  localparam logic [4:0] R_W   = 5'd9;
  localparam logic [4:0] R_S00 = 5'd10;
  localparam logic [4:0] R_S01 = 5'd11;
  localparam logic [4:0] R_S11 = 5'd12;
  localparam logic [4:0] R_P00 = 5'd13;
  localparam logic [4:0] R_P01 = 5'd14;
  localparam logic [4:0] R_P10 = 5'd15;
  localparam logic [4:0] R_P11 = 5'd16;
  localparam logic [4:0] R_A00 = 5'd17;
  localparam logic [4:0] R_A01 = 5'd18;
  localparam logic [4:0] R_A11 = 5'd19;
  localparam logic [4:0] R_TR  = 5'd20;
  localparam logic [4:0] R_N00 = 5'd21;
  localparam logic [4:0] R_N01 = 5'd22;
  localparam logic [4:0] R_N11 = 5'd23;
  localparam logic [4:0] R_C0X = 5'd24;
  localparam logic [4:0] R_C0Y = 5'd25;
  localparam logic [4:0] R_C0Z = 5'd26;
  localparam logic [4:0] R_C1X = 5'd27;
  localparam logic [4:0] R_C1Y = 5'd28;
  localparam logic [4:0] R_C1Z = 5'd29;
  localparam int unsigned RF_DEPTH = 30;

  // result slots
  localparam logic [3:0] OI_V0X = 4'd0;
  localparam logic [3:0] OI_V0Y = 4'd1;
  localparam logic [3:0] OI_V0Z = 4'd2;
  localparam logic [3:0] OI_V1X = 4'd3;
  localparam logic [3:0] OI_V1Y = 4'd4;
  localparam logic [3:0] OI_V1Z = 4'd5;
  localparam logic [3:0] OI_V2X = 4'd6;
  localparam logic [3:0] OI_V2Y = 4'd7;
  localparam logic [3:0] OI_V2Z = 4'd8;
  localparam logic [3:0] OI_DET = 4'd9;

  typedef enum logic [1:0] {B_MEM, B_ONE, B_TWO, B_GAIN} bsel_e;

  typedef struct packed {
    logic [4:0] a;
    logic [4:0] b;
    bsel_e      bsel;
    logic       first;
    logic       raw;
    logic       neg;
    logic       dbl;
    logic       wr;
    logic       oe;
    logic       fin;
    logic [4:0] dst;
    logic [3:0] oi;
  } op_t;

  localparam logic [6:0] F_NONE  = 7'h00;
  localparam logic [6:0] F_FIRST = 7'h40;
  localparam logic [6:0] F_RAW   = 7'h20;
  localparam logic [6:0] F_NEG   = 7'h10;
  localparam logic [6:0] F_DBL   = 7'h08;
  localparam logic [6:0] F_WR    = 7'h04;
  localparam logic [6:0] F_OUT   = 7'h02;
  localparam logic [6:0] F_FIN   = 7'h01;

  function automatic op_t mk(input logic [4:0] a, input logic [4:0] b, input bsel_e bs,
                             input logic [6:0] fl, input logic [4:0] dst,
                             input logic [3:0] oi);
    op_t o;
    o.a     = a;
    o.b     = b;
    o.bsel  = bs;
    o.first = fl[6];
    o.raw   = fl[5];
    o.neg   = fl[4];
    o.dbl   = fl[3];
    o.wr    = fl[2];
    o.oe    = fl[1];
    o.fin   = fl[0];
    o.dst   = dst;
    o.oi    = oi;
    return o;
  endfunction

  function automatic op_t op_at(input logic [STEP_W-1:0] s);
    op_t o;
    case (s)
      // edge gram matrix
      7'd0:  o = mk(R_F0X, R_F0X, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd1:  o = mk(R_F0Y, R_F0Y, B_MEM, F_NONE, R_F0X, OI_V0X);
      7'd2:  o = mk(R_F0Z, R_F0Z, B_MEM, F_WR, R_S00, OI_V0X);
      7'd3:  o = mk(R_F0X, R_F1X, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd4:  o = mk(R_F0Y, R_F1Y, B_MEM, F_NONE, R_F0X, OI_V0X);
      7'd5:  o = mk(R_F0Z, R_F1Z, B_MEM, F_WR, R_S01, OI_V0X);
      7'd6:  o = mk(R_F1X, R_F1X, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd7:  o = mk(R_F1Y, R_F1Y, B_MEM, F_NONE, R_F0X, OI_V0X);
      7'd8:  o = mk(R_F1Z, R_F1Z, B_MEM, F_WR, R_S11, OI_V0X);
      // metric sandwich into a
      7'd9:  o = mk(R_MA, R_S00, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd10: o = mk(R_MB, R_S01, B_MEM, F_WR, R_P00, OI_V0X);
      7'd11: o = mk(R_MA, R_S01, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd12: o = mk(R_MB, R_S11, B_MEM, F_WR, R_P01, OI_V0X);
      7'd13: o = mk(R_MB, R_S00, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd14: o = mk(R_MD, R_S01, B_MEM, F_WR, R_P10, OI_V0X);
      7'd15: o = mk(R_MB, R_S01, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd16: o = mk(R_MD, R_S11, B_MEM, F_WR, R_P11, OI_V0X);
      7'd17: o = mk(R_P00, R_MA, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd18: o = mk(R_P01, R_MB, B_MEM, F_WR, R_A00, OI_V0X);
      7'd19: o = mk(R_P00, R_MB, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd20: o = mk(R_P01, R_MD, B_MEM, F_WR, R_A01, OI_V0X);
      7'd21: o = mk(R_P10, R_MB, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd22: o = mk(R_P11, R_MD, B_MEM, F_WR, R_A11, OI_V0X);
      // trace and energy derivative
      7'd23: o = mk(R_A00, R_F0X, B_ONE, F_FIRST, R_F0X, OI_V0X);
      7'd24: o = mk(R_A11, R_F0X, B_ONE, F_WR, R_TR, OI_V0X);
      7'd25: o = mk(R_TR, R_F0X, B_ONE, F_FIRST, R_F0X, OI_V0X);
      7'd26: o = mk(R_A11, R_F0X, B_TWO, F_NEG | F_WR, R_S00, OI_V0X);
      7'd27: o = mk(R_A01, R_F0X, B_ONE, F_FIRST | F_DBL | F_WR, R_S01, OI_V0X);
      7'd28: o = mk(R_TR, R_F0X, B_ONE, F_FIRST, R_F0X, OI_V0X);
      7'd29: o = mk(R_A00, R_F0X, B_TWO, F_NEG | F_WR, R_S11, OI_V0X);
      // metric sandwich into n
      7'd30: o = mk(R_MA, R_S00, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd31: o = mk(R_MB, R_S01, B_MEM, F_WR, R_P00, OI_V0X);
      7'd32: o = mk(R_MA, R_S01, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd33: o = mk(R_MB, R_S11, B_MEM, F_WR, R_P01, OI_V0X);
      7'd34: o = mk(R_MB, R_S00, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd35: o = mk(R_MD, R_S01, B_MEM, F_WR, R_P10, OI_V0X);
      7'd36: o = mk(R_MB, R_S01, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd37: o = mk(R_MD, R_S11, B_MEM, F_WR, R_P11, OI_V0X);
      7'd38: o = mk(R_P00, R_MA, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd39: o = mk(R_P01, R_MB, B_MEM, F_WR, R_N00, OI_V0X);
      7'd40: o = mk(R_P00, R_MB, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd41: o = mk(R_P01, R_MD, B_MEM, F_WR, R_N01, OI_V0X);
      7'd42: o = mk(R_P10, R_MB, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd43: o = mk(R_P11, R_MD, B_MEM, F_WR, R_N11, OI_V0X);
      // d = 2 f n
      7'd44: o = mk(R_F0X, R_N00, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd45: o = mk(R_F1X, R_N01, B_MEM, F_DBL | F_WR, R_C0X, OI_V0X);
      7'd46: o = mk(R_F0X, R_N01, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd47: o = mk(R_F1X, R_N11, B_MEM, F_DBL | F_WR, R_C1X, OI_V0X);
      7'd48: o = mk(R_F0Y, R_N00, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd49: o = mk(R_F1Y, R_N01, B_MEM, F_DBL | F_WR, R_C0Y, OI_V0X);
      7'd50: o = mk(R_F0Y, R_N01, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd51: o = mk(R_F1Y, R_N11, B_MEM, F_DBL | F_WR, R_C1Y, OI_V0X);
      7'd52: o = mk(R_F0Z, R_N00, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd53: o = mk(R_F1Z, R_N01, B_MEM, F_DBL | F_WR, R_C0Z, OI_V0X);
      7'd54: o = mk(R_F0Z, R_N01, B_MEM, F_FIRST, R_F0X, OI_V0X);
      7'd55: o = mk(R_F1Z, R_N11, B_MEM, F_DBL | F_WR, R_C1Z, OI_V0X);
      // weight and gain
      7'd56: o = mk(R_C0X, R_W, B_MEM, F_FIRST | F_WR, R_C0X, OI_V0X);
      7'd57: o = mk(R_C0X, R_W, B_GAIN, F_FIRST | F_WR | F_OUT, R_C0X, OI_V1X);
      7'd58: o = mk(R_C0Y, R_W, B_MEM, F_FIRST | F_WR, R_C0Y, OI_V0X);
      7'd59: o = mk(R_C0Y, R_W, B_GAIN, F_FIRST | F_WR | F_OUT, R_C0Y, OI_V1Y);
      7'd60: o = mk(R_C0Z, R_W, B_MEM, F_FIRST | F_WR, R_C0Z, OI_V0X);
      7'd61: o = mk(R_C0Z, R_W, B_GAIN, F_FIRST | F_WR | F_OUT, R_C0Z, OI_V1Z);
      7'd62: o = mk(R_C1X, R_W, B_MEM, F_FIRST | F_WR, R_C1X, OI_V0X);
      7'd63: o = mk(R_C1X, R_W, B_GAIN, F_FIRST | F_WR | F_OUT, R_C1X, OI_V2X);
      7'd64: o = mk(R_C1Y, R_W, B_MEM, F_FIRST | F_WR, R_C1Y, OI_V0X);
      7'd65: o = mk(R_C1Y, R_W, B_GAIN, F_FIRST | F_WR | F_OUT, R_C1Y, OI_V2Y);
      7'd66: o = mk(R_C1Z, R_W, B_MEM, F_FIRST | F_WR, R_C1Z, OI_V0X);
      7'd67: o = mk(R_C1Z, R_W, B_GAIN, F_FIRST | F_WR | F_OUT, R_C1Z, OI_V2Z);
      // vertex 0
      7'd68: o = mk(R_C0X, R_F0X, B_ONE, F_FIRST | F_NEG, R_F0X, OI_V0X);
      7'd69: o = mk(R_C1X, R_F0X, B_ONE, F_NEG | F_OUT, R_F0X, OI_V0X);
      7'd70: o = mk(R_C0Y, R_F0X, B_ONE, F_FIRST | F_NEG, R_F0X, OI_V0X);
      7'd71: o = mk(R_C1Y, R_F0X, B_ONE, F_NEG | F_OUT, R_F0X, OI_V0Y);
      7'd72: o = mk(R_C0Z, R_F0X, B_ONE, F_FIRST | F_NEG, R_F0X, OI_V0X);
      7'd73: o = mk(R_C1Z, R_F0X, B_ONE, F_NEG | F_OUT, R_F0X, OI_V0Z);
      // determinant, then trace squared left in the accumulator
      7'd74: o = mk(R_A00, R_A11, B_MEM, F_FIRST | F_RAW, R_F0X, OI_V0X);
      7'd75: o = mk(R_A01, R_A01, B_MEM, F_RAW | F_NEG | F_OUT, R_F0X, OI_DET);
      7'd76: o = mk(R_TR, R_TR, B_MEM, F_FIRST | F_RAW | F_FIN, R_F0X, OI_V0X);
      default: o = mk(R_F0X, R_F0X, B_ONE, F_FIRST | F_FIN, R_F0X, OI_V0X);
    endcase
    return o;
  endfunction

  // round(+-mag * w / 2^s) half away from zero, saturated, from the two partial products
  function automatic logic [63:0] mul_wide(input logic [63:0] phi, input logic [63:0] plo,
                                           input logic neg, input int unsigned s);
    logic [64:0] t;
    logic        ovf;
    logic [63:0] r;
    ovf = (phi >> (31 + s)) != 64'd0;
    t   = ({1'b0, phi} << (32 - s)) + (({1'b0, plo} + (65'd1 << (s - 1))) >> s);
    if (ovf) begin
      r = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    end else if (!neg && t > 65'h0_7fff_ffff_ffff_ffff) begin
      r = 64'h7fff_ffff_ffff_ffff;
    end else if (neg && t > 65'h0_8000_0000_0000_0000) begin
      r = 64'h8000_0000_0000_0000;
    end else begin
      r = neg ? (64'd0 - t[63:0]) : t[63:0];
    end
    return r;
  endfunction

endpackage

[rtl/tdeg_front.sv]
// input side: takes triangle items from the stream and queues them for the datapath
// depends on tdeg_pkg
`timescale 1ns / 1ps

module tdeg_front import tdeg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [IN_W-1:0] s_axis_tdata,
  input  logic            s_axis_tlast,
  output item_t           item_o,
  output logic            item_valid_o,
  input  logic            item_pop_i
);

  localparam int unsigned DEPTH = 2;

  item_t      q_mem [DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  item_t      item_in;

  assign item_in.word = s_axis_tdata;
  assign item_in.last = s_axis_tlast;

  assign s_axis_tready = cnt_q != 2'(DEPTH);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = item_pop_i && item_valid_o;
  assign item_valid_o  = cnt_q != 2'd0;
  assign item_o        = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/tdeg_back.sv]
// datapath: op sequencer over a register file and one shared multiplier, energy sum, result register
// depends on tdeg_pkg
`timescale 1ns / 1ps

module tdeg_back import tdeg_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      gain_i,
  input  item_t            item_i,
  input  logic             item_valid_i,
  output logic             item_pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RD, S_MUL, S_ACC, S_EN, S_LO, S_HI, S_FIN
  } state_e;

  localparam logic signed [32:0]  ONE_Q  = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [32:0]  TWO_Q  = 33'sd1 <<< (FRAC_BITS + 1);
  localparam logic signed [ACC_W:0] MAX32_X = (ACC_W + 1)'(S32_MAX);
  localparam logic signed [ACC_W:0] MIN32_X = (ACC_W + 1)'(S32_MIN);

  state_e                    state_q;
  logic [3:0]                cnt_q;
  logic [STEP_W-1:0]         step_q;
  logic [31:0]               rf_mem [RF_DEPTH];
  logic [31:0]               rd_a_q, rd_b_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_new, term, term_n;
  logic signed [PROD_W-1:0]  rnd;
  logic signed [ACC_W:0]     pre;
  logic [31:0]               res32;
  logic [8:0][31:0]          res_q;
  logic signed [63:0]        det_q;
  logic                      en_neg_q;
  logic [63:0]               mag_q;
  logic [63:0]               plo_q;
  logic [31:0]               w_q;
  logic                      last_q;
  logic signed [63:0]        energy_q;
  logic                      out_valid_q;
  logic [OUT_W-1:0]          out_data_q;
  op_t                       op;
  logic signed [32:0]        mul_a, mul_b;
  logic signed [63:0]        tr2, det4, en, wen, half, sum, total;
  logic signed [64:0]        diff, sum_x;
  logic [63:0]               mag_d;

  assign op            = op_at(step_q);
  assign item_pop_o    = (state_q == S_LOAD) && (cnt_q == 4'(NUM_WORDS - 1));
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // shared multiplier operands
  always_comb begin
    case (state_q)
      S_LO: begin
        mul_a = {1'b0, mag_q[31:0]};
        mul_b = {1'b0, w_q};
      end
      S_HI: begin
        mul_a = {1'b0, mag_q[63:32]};
        mul_b = {1'b0, w_q};
      end
      default: begin
        mul_a = {rd_a_q[31], rd_a_q};
        case (op.bsel)
          B_MEM:   mul_b = (op.b == R_W) ? {1'b0, rd_b_q} : {rd_b_q[31], rd_b_q};
          B_ONE:   mul_b = ONE_Q;
          B_TWO:   mul_b = TWO_Q;
          B_GAIN:  mul_b = {1'b0, gain_i};
          default: mul_b = ONE_Q;
        endcase
      end
    endcase
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // rounding, accumulate, saturate
  always_comb begin
    rnd     = (prod_q >>> FRAC_BITS) + $signed({{(PROD_W-1){1'b0}}, prod_q[FRAC_BITS-1]});
    term    = op.raw ? ACC_W'(prod_q) : ACC_W'(rnd);
    term_n  = op.neg ? -term : term;
    acc_new = (op.first ? '0 : acc_q) + term_n;
    pre     = op.dbl ? {acc_new, 1'b0} : {acc_new[ACC_W-1], acc_new};
    if (pre > MAX32_X) begin
      res32 = 32'h7fff_ffff;
    end else if (pre < MIN32_X) begin
      res32 = 32'h8000_0000;
    end else begin
      res32 = pre[31:0];
    end
  end

  // energy term
  always_comb begin
    tr2 = acc_q[63:0];
    if (det_q[63:61] != 3'b000 && det_q[63:61] != 3'b111) begin
      det4 = det_q[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end else begin
      det4 = det_q <<< 2;
    end
    diff = 65'(tr2) - 65'(det4);
    if (diff[64] != diff[63]) begin
      en = diff[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end else begin
      en = diff[63:0];
    end
    mag_d = en[63] ? (64'd0 - en) : en;
    wen   = mul_wide(prod_q[63:0], plo_q, en_neg_q, FRAC_BITS);
    half  = mul_wide(prod_q[63:0], plo_q, en_neg_q, FRAC_BITS + 1);
    sum_x = 65'(energy_q) + 65'(wen);
    if (sum_x[64] != sum_x[63]) begin
      sum = sum_x[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end else begin
      sum = sum_x[63:0];
    end
    total = last_q ? ((sum >>> 1) + $signed({63'd0, sum[0]})) : 64'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      rf_mem[5'(cnt_q)] <= item_i.word[cnt_q];
    end else if (state_q == S_ACC && op.wr) begin
      rf_mem[op.dst] <= res32;
    end
    if (state_q == S_RD) begin
      rd_a_q <= rf_mem[op.a];
      rd_b_q <= rf_mem[op.b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 4'd0;
      step_q      <= '0;
      energy_q    <= 64'sd0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          cnt_q <= 4'd0;
          if (item_valid_i) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(NUM_WORDS - 1)) begin
            w_q     <= item_i.word[NUM_WORDS-1];
            last_q  <= item_i.last;
            step_q  <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= prod_d;
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q <= acc_new;
          if (op.oe) begin
            if (op.oi == OI_DET) begin
              det_q <= acc_new[63:0];
            end else begin
              res_q[op.oi] <= res32;
            end
          end
          if (op.fin) begin
            state_q <= S_EN;
          end else begin
            step_q  <= step_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_EN: begin
          mag_q    <= mag_d;
          en_neg_q <= en[63];
          state_q  <= S_LO;
        end
        S_LO: begin
          prod_q  <= prod_d;
          state_q <= S_HI;
        end
        S_HI: begin
          plo_q   <= prod_q[63:0];
          prod_q  <= prod_d;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            out_data_q  <= {total, half, res_q};
            out_valid_q <= 1'b1;
            energy_q    <= last_q ? 64'sd0 : sum;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/triangle_deformation_energy_grad.sv]
// top level: triangle stretch energy and vertex gradient, gain register, stream ports
// depends on tdeg_pkg, tdeg_front and tdeg_back
`timescale 1ns / 1ps

// One triangle item in, one result item out. A two-entry input queue takes items while the
// datapath works; the datapath runs a fixed sequence of 77 multiply-accumulate ops through one
// 33x33 multiplier, each through register-file read, multiply, and round and accumulate states,
// after a register load of the ten input words, then states for the energy term and running sum
// (S_EN, S_LO, S_HI, S_FIN) and a return to idle. The result waits in its own register while the
// next triangle starts. The gain register takes a write in any cycle.
module triangle_deformation_energy_grad import tdeg_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [31:0]      cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // edge_one_x, edge_one_y, edge_one_z, edge_two_x, edge_two_y, edge_two_z,
  // metric_a, metric_b, metric_d, area_weight
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // grad_v0_x, grad_v0_y, grad_v0_z, grad_v1_x, grad_v1_y, grad_v1_z,
  // grad_v2_x, grad_v2_y, grad_v2_z, triangle_energy, total_energy
  output logic [OUT_W-1:0] m_axis_tdata
);

  logic [31:0] gain_q;
  item_t       item;
  logic        item_valid;
  logic        item_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 32'd1 << FRAC_BITS;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  tdeg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_pop_i    (item_pop)
  );

  tdeg_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gain_i        (gain_q),
    .item_i        (item),
    .item_valid_i  (item_valid),
    .item_pop_o    (item_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[tb/tb_triangle_deformation_energy_grad.sv]
// self-checking bench for triangle_deformation_energy_grad: stream driver, stalling receiver,
// in-bench fixed-point predictor of gradient and energy; depends on tdeg_pkg and the rtl
`timescale 1ns / 1ps

module tb_triangle_deformation_energy_grad;
  import tdeg_pkg::*;

  localparam int unsigned Q = FRAC_BITS_DEF;
  localparam longint      I64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint      I64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [IN_W-1:0] data;
    logic            last;
  } tri_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [31:0]      cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;  // edges, metric a b d, area weight
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;       // nine gradients, triangle energy, total energy

  tri_item_t        tri_pending[$];
  logic [OUT_W-1:0] grad_expected[$];
  logic [31:0]      gain_model = 32'd65536;
  longint           energy_sum = 0;
  int unsigned      errors = 0;
  int unsigned      results_seen = 0;

  triangle_deformation_energy_grad u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sat32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint round_shift(input longint x, input int unsigned s);
    return (x >>> s) + ((x >> (s - 1)) & 64'sd1);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return round_shift(a * b, Q);
  endfunction

  function automatic longint add_sat64(input longint a, input longint b);
    if (b > 0 && a > I64_MAX - b) return I64_MAX;
    if (b < 0 && a < I64_MIN - b) return I64_MIN;
    return a + b;
  endfunction

  function automatic longint sub_sat64(input longint a, input longint b);
    if (b < 0 && a > I64_MAX + b) return I64_MAX;
    if (b > 0 && a < I64_MIN + b) return I64_MIN;
    return a - b;
  endfunction

  function automatic longint weight_scale(input longint e, input logic [31:0] w,
                                          input int unsigned s);
    logic        neg;
    logic [63:0] mag, plo, phi, t;
    neg = e < 0;
    mag = neg ? 64'd0 - 64'(e) : 64'(e);
    plo = {32'd0, mag[31:0]} * {32'd0, w};
    phi = {32'd0, mag[63:32]} * {32'd0, w};
    if ((phi >> (31 + s)) != 64'd0) return neg ? I64_MIN : I64_MAX;
    t = (phi << (32 - s)) + ((plo + (64'd1 << (s - 1))) >> s);
    if (!neg && t > 64'h7fff_ffff_ffff_ffff) return I64_MAX;
    if (neg && t > 64'h8000_0000_0000_0000) return I64_MIN;
    return neg ? longint'(64'd0 - t) : longint'(t);
  endfunction

  function automatic void metric_sandwich(input longint a, b, d, s00, s01, s11,
                                          output longint o00, o01, o11);
    longint p00, p01, p10, p11;
    p00 = sat32(qmul(a, s00) + qmul(b, s01));
    p01 = sat32(qmul(a, s01) + qmul(b, s11));
    p10 = sat32(qmul(b, s00) + qmul(d, s01));
    p11 = sat32(qmul(b, s01) + qmul(d, s11));
    o00 = sat32(qmul(p00, a) + qmul(p01, b));
    o01 = sat32(qmul(p00, b) + qmul(p01, d));
    o11 = sat32(qmul(p10, b) + qmul(p11, d));
  endfunction

  // also advances the running energy sum
  function automatic logic [OUT_W-1:0] predict_triangle(input tri_item_t it);
    longint           e1[3], e2[3], v1[3], v2[3];
    longint           ma, mb, md, g00, g01, g11, a00, a01, a11, n00, n01, n11;
    longint           tr, d00, d01, d11, det, det4, en, c0, c1;
    logic [31:0]      w;
    logic [OUT_W-1:0] r;
    for (int k = 0; k < 3; k++) begin
      e1[k] = longint'($signed(it.data[32*k +: 32]));
      e2[k] = longint'($signed(it.data[32*(k+3) +: 32]));
    end
    ma = longint'($signed(it.data[192 +: 32]));
    mb = longint'($signed(it.data[224 +: 32]));
    md = longint'($signed(it.data[256 +: 32]));
    w  = it.data[288 +: 32];
    g00 = sat32(qmul(e1[0], e1[0]) + qmul(e1[1], e1[1]) + qmul(e1[2], e1[2]));
    g01 = sat32(qmul(e1[0], e2[0]) + qmul(e1[1], e2[1]) + qmul(e1[2], e2[2]));
    g11 = sat32(qmul(e2[0], e2[0]) + qmul(e2[1], e2[1]) + qmul(e2[2], e2[2]));
    metric_sandwich(ma, mb, md, g00, g01, g11, a00, a01, a11);
    tr  = sat32(a00 + a11);
    d00 = sat32(tr - 2 * a11);
    d01 = sat32(2 * a01);
    d11 = sat32(tr - 2 * a00);
    metric_sandwich(ma, mb, md, d00, d01, d11, n00, n01, n11);
    for (int k = 0; k < 3; k++) begin
      c0 = sat32(2 * (qmul(e1[k], n00) + qmul(e2[k], n01)));
      c1 = sat32(2 * (qmul(e1[k], n01) + qmul(e2[k], n11)));
      v1[k] = sat32(qmul(sat32(qmul(c0, longint'(w))), longint'(gain_model)));
      v2[k] = sat32(qmul(sat32(qmul(c1, longint'(w))), longint'(gain_model)));
      r[32*k +: 32]     = 32'(sat32(-(v1[k] + v2[k])));
      r[32*(k+3) +: 32] = 32'(v1[k]);
      r[32*(k+6) +: 32] = 32'(v2[k]);
    end
    det = a00 * a11 - a01 * a01;
    if (det > I64_MAX / 4) det4 = I64_MAX;
    else if (det < I64_MIN / 4) det4 = I64_MIN;
    else det4 = det * 4;
    en = sub_sat64(tr * tr, det4);
    r[288 +: 64] = 64'(weight_scale(en, w, Q + 1));
    energy_sum = add_sat64(energy_sum, weight_scale(en, w, Q));
    if (it.last) begin
      r[352 +: 64] = 64'(round_shift(energy_sum, 1));
      energy_sum = 0;
    end else begin
      r[352 +: 64] = '0;
    end
    return r;
  endfunction

  // driver: bursts and gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        grad_expected.push_back(predict_triangle(tri_pending.pop_front()));
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (tri_pending.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tri_pending[0].data;
        s_axis_tlast  <= tri_pending[0].last;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: changing stall modes plus one long hold-off
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;
  int unsigned cyc = 0;
  bit          held_once = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc = cyc + 1;
      if (!held_once && results_seen == 40) begin
        held_once = 1'b1;
        hold_left = 4000;
      end
      if (mode_left == 0) begin
        mode_left  = $urandom_range(100, 3000);
        stall_mode = $urandom_range(0, 2);
      end else begin
        mode_left = mode_left - 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ((cyc % 7) < 2);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen = results_seen + 1;
      if (grad_expected.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
        errors = errors + 1;
      end else begin
        exp_v = grad_expected.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (exp_v[32*k +: 32] !== m_axis_tdata[32*k +: 32]) begin
            $display("%0t: gradient %0d expected %h actual %h", $time, k,
                     exp_v[32*k +: 32], m_axis_tdata[32*k +: 32]);
            errors = errors + 1;
          end
        end
        for (int k = 0; k < 2; k++) begin
          if (exp_v[288+64*k +: 64] !== m_axis_tdata[288+64*k +: 64]) begin
            $display("%0t: energy %0d expected %h actual %h", $time, k,
                     exp_v[288+64*k +: 64], m_axis_tdata[288+64*k +: 64]);
            errors = errors + 1;
          end
        end
      end
    end
  end

  function automatic logic [31:0] pick_word(input int unsigned kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0001_ffff);
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'd0;
          3: return 32'h0001_0000;
          4: return 32'hffff_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic tri_item_t random_triangle();
    tri_item_t   it;
    int unsigned kind;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    kind = (roll < 6) ? 1 : (roll < 8) ? 0 : 2;
    for (int k = 0; k < 9; k++) begin
      it.data[32*k +: 32] = ($urandom_range(0, 19) == 0) ? pick_word($urandom_range(0, 2))
                                                          : pick_word(kind);
    end
    it.data[288 +: 32] = (kind == 1) ? $urandom_range(0, 32'h0004_0000) : pick_word(kind);
    it.last = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  function automatic tri_item_t make_triangle(input logic [31:0] e, m_diag, m_off, w,
                                              input logic lst);
    tri_item_t it;
    for (int k = 0; k < 6; k++) it.data[32*k +: 32] = e;
    it.data[192 +: 32] = m_diag;
    it.data[224 +: 32] = m_off;
    it.data[256 +: 32] = m_diag;
    it.data[288 +: 32] = w;
    it.last = lst;
    return it;
  endfunction

  task automatic wait_idle();
    while (tri_pending.size() > 0 || grad_expected.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    gain_model = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n);
    for (int i = 0; i < n; i++) tri_pending.push_back(random_triangle());
    wait_idle();
  endtask

  initial begin
    tri_item_t it;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zeros, unit triangle, extremes, zero and full weight, energy totals
    tri_pending.push_back(make_triangle(32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000, 1'b0));
    it = make_triangle(32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000, 1'b0);
    it.data[0 +: 32] = 32'h0001_0000;
    it.data[128 +: 32] = 32'h0001_0000;
    tri_pending.push_back(it);
    it.data[0 +: 32] = 32'h0002_0000;
    it.last = 1'b1;
    tri_pending.push_back(it);
    tri_pending.push_back(make_triangle(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'hffff_ffff, 1'b0));
    tri_pending.push_back(make_triangle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'hffff_ffff, 1'b1));
    tri_pending.push_back(make_triangle(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                        32'd0, 1'b0));
    tri_pending.push_back(make_triangle(32'h0003_0000, 32'hfffe_0000, 32'h0001_8000,
                                        32'h0000_8000, 1'b0));
    tri_pending.push_back(make_triangle(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff,
                                        32'h0000_0001, 1'b1));
    tri_pending.push_back(make_triangle(32'h0100_0000, 32'h0100_0000, 32'd0,
                                        32'h7fff_ffff, 1'b0));
    tri_pending.push_back(make_triangle(32'h0000_8000, 32'h0001_0000, 32'h0000_ffff,
                                        32'h8000_0000, 1'b1));
    for (int i = 0; i < 10; i++) tri_pending.push_back(random_triangle());
    wait_idle();
    run_random(500);
    write_gain(32'd0);
    run_random(150);
    write_gain(32'hffff_ffff);
    run_random(200);
    write_gain(32'h0003_0000);
    run_random(300);
    write_gain($urandom());
    run_random(200);
    write_gain(32'd65536);
    run_random(150);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
